FILE: hw/rtl/ctdq_pkg.sv
// ----------------------------------------------------------------------------
// ctdq_pkg
// Shared constants, types and helpers for the CAN transmit drop-oldest queue.
// ----------------------------------------------------------------------------
package ctdq_pkg;

	localparam int QUEUE_DEPTH  = 8;
	localparam int DRAIN_BUDGET = 3;

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int BUD_W   = $clog2(DRAIN_BUDGET + 1);
	localparam int ID_W    = 11;
	localparam int LEN_W   = 4;
	localparam int PAY_W   = 64;
	localparam int MB_W    = 2;
	localparam int CTR_W   = 32;
	localparam int DEPTH_W = 4;
	localparam int SLOT_W  = LEN_W + ID_W + PAY_W;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

	localparam logic FUNC_SUBMIT = 1'b0;
	localparam logic FUNC_DRAIN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_CHK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic               emit_valid;
		logic [ID_W-1:0]    emit_id;
		logic [LEN_W-1:0]   emit_len;
		logic [PAY_W-1:0]   emit_payload;
		logic               accepted;
		logic               dropped_oldest;
		logic [DEPTH_W-1:0] queue_depth;
		logic [CTR_W-1:0]   sent_total;
		logic [CTR_W-1:0]   drop_total;
		logic               last;
	} res_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [DEPTH_W-1:0] depth_out(input logic [CNT_W-1:0] f);
		logic [CNT_W+DEPTH_W-1:0] t;
		t = {{DEPTH_W{1'b0}}, f};
		return t[DEPTH_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/ctdq_ram.sv
// ----------------------------------------------------------------------------
// ctdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/can_tx_drop_oldest_queue_core.sv
// ----------------------------------------------------------------------------
// can_tx_drop_oldest_queue_core
// Transmit queue in front of CAN mailboxes: direct send or drop-oldest ring.
// ----------------------------------------------------------------------------
// One word at a time. A submit gives one result word. A drain reads the ring
// head through the single registered read port of the slot RAM, examines at most
// DRAIN_BUDGET head frames, and gives one result word per frame sent (or one empty
// word). Output back-pressure can stall the block. The slot RAM needs no clearing
// after reset.
module can_tx_drop_oldest_queue_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [ctdq_pkg::ID_W-1:0]      frame_id,
	input  logic [ctdq_pkg::LEN_W-1:0]     frame_len,
	input  logic [ctdq_pkg::PAY_W-1:0]     frame_payload,
	input  logic [ctdq_pkg::MB_W-1:0]      free_mailboxes,
	input  logic                           bus_is_off,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           emit_valid,
	output logic [ctdq_pkg::ID_W-1:0]      emit_id,
	output logic [ctdq_pkg::LEN_W-1:0]     emit_len,
	output logic [ctdq_pkg::PAY_W-1:0]     emit_payload,
	output logic                           accepted,
	output logic                           dropped_oldest,
	output logic [ctdq_pkg::DEPTH_W-1:0]   queue_depth,
	output logic [ctdq_pkg::CTR_W-1:0]     sent_total,
	output logic [ctdq_pkg::CTR_W-1:0]     drop_total,
	output logic                           last
);

	ctdq_pkg::state_t state_q, state_d;

	logic                          link_en_q;
	logic                          func_q;
	logic [ctdq_pkg::ID_W-1:0]     id_q;
	logic [ctdq_pkg::LEN_W-1:0]    len_q;
	logic [ctdq_pkg::PAY_W-1:0]    pay_q;
	logic                          boff_q;
	logic [ctdq_pkg::MB_W-1:0]     mb_q, mb_d;
	logic [ctdq_pkg::BUD_W-1:0]    bud_q, bud_d;

	logic [ctdq_pkg::PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
	logic [ctdq_pkg::PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
	logic [ctdq_pkg::CNT_W-1:0]    fill_q, fill_d;
	logic [ctdq_pkg::CTR_W-1:0]    sent_q, sent_d;
	logic [ctdq_pkg::CTR_W-1:0]    drop_q, drop_d;

	logic                          out_valid_q;
	ctdq_pkg::res_t                out_q, out_d;
	logic                          out_load;
	logic                          hold_v_q, hold_v_d;
	ctdq_pkg::res_t                hold_q, hold_d;

	logic                          ram_we;
	logic [ctdq_pkg::SLOT_W-1:0]   ram_rdata;
	logic [ctdq_pkg::ID_W-1:0]     head_id;
	logic [ctdq_pkg::LEN_W-1:0]    head_len;
	logic [ctdq_pkg::PAY_W-1:0]    head_pay;
	logic                          head_ok;
	logic                          out_free;
	logic                          direct;
	logic                          full;
	logic                          drain_idle;
	logic                          more;
	logic                          in_acc;

	ctdq_ram #(
		.WIDTH(ctdq_pkg::SLOT_W),
		.DEPTH(ctdq_pkg::QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata ({len_q, id_q, pay_q}),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	assign head_pay = ram_rdata[ctdq_pkg::PAY_W-1:0];
	assign head_id  = ram_rdata[ctdq_pkg::PAY_W+ctdq_pkg::ID_W-1:ctdq_pkg::PAY_W];
	assign head_len = ram_rdata[ctdq_pkg::SLOT_W-1:ctdq_pkg::PAY_W+ctdq_pkg::ID_W];
	assign head_ok  = (head_len <= ctdq_pkg::MAX_LEN);

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ctdq_pkg::ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign direct     = (fill_q == '0) && !boff_q && (mb_q != '0) && (len_q <= ctdq_pkg::MAX_LEN);
	assign full       = (fill_q == ctdq_pkg::CNT_W'(ctdq_pkg::QUEUE_DEPTH));
	assign drain_idle = (fill_q == '0) || boff_q || (mb_q == '0);
	assign more       = (bud_q > ctdq_pkg::BUD_W'(1)) && (fill_q > ctdq_pkg::CNT_W'(1)) &&
	                    (mb_q > ctdq_pkg::MB_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctdq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ctdq_pkg::ST_EXEC;
				end
			end
			ctdq_pkg::ST_EXEC: begin
				if (!link_en_q) begin
					state_d = ctdq_pkg::ST_FLUSH;
				end else if (func_q == ctdq_pkg::FUNC_SUBMIT) begin
					if (out_free) begin
						state_d = ctdq_pkg::ST_IDLE;
					end
				end else if (drain_idle) begin
					state_d = ctdq_pkg::ST_FLUSH;
				end else begin
					state_d = ctdq_pkg::ST_RD;
				end
			end
			ctdq_pkg::ST_RD: begin
				state_d = ctdq_pkg::ST_CHK;
			end
			ctdq_pkg::ST_CHK: begin
				if (!head_ok) begin
					state_d = ctdq_pkg::ST_FLUSH;
				end else if (!hold_v_q || out_free) begin
					state_d = more ? ctdq_pkg::ST_RD : ctdq_pkg::ST_FLUSH;
				end
			end
			ctdq_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = ctdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ctdq_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath control
	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		fill_d   = fill_q;
		sent_d   = sent_q;
		drop_d   = drop_q;
		mb_d     = mb_q;
		bud_d    = bud_q;
		hold_v_d = hold_v_q;
		hold_d   = hold_q;
		out_load = 1'b0;
		out_d    = out_q;
		ram_we   = 1'b0;
		unique case (state_q)
			ctdq_pkg::ST_EXEC: begin
				if (link_en_q && (func_q == ctdq_pkg::FUNC_SUBMIT) && out_free) begin
					out_load = 1'b1;
					out_d    = '0;
					out_d.accepted = 1'b1;
					out_d.last     = 1'b1;
					if (direct) begin
						sent_d             = sent_q + ctdq_pkg::CTR_W'(1);
						out_d.emit_valid   = 1'b1;
						out_d.emit_id      = id_q;
						out_d.emit_len     = len_q;
						out_d.emit_payload = pay_q;
					end else begin
						ram_we   = 1'b1;
						wr_ptr_d = ctdq_pkg::next_ptr(wr_ptr_q);
						if (full) begin
							rd_ptr_d = ctdq_pkg::next_ptr(rd_ptr_q);
							drop_d   = drop_q + ctdq_pkg::CTR_W'(1);
						end else begin
							fill_d = fill_q + ctdq_pkg::CNT_W'(1);
						end
						out_d.dropped_oldest = full;
					end
					out_d.queue_depth = ctdq_pkg::depth_out(fill_d);
					out_d.sent_total  = sent_d;
					out_d.drop_total  = drop_d;
				end
			end
			ctdq_pkg::ST_CHK: begin
				if (head_ok && (!hold_v_q || out_free)) begin
					if (hold_v_q) begin
						out_load = 1'b1;
						out_d    = hold_q;
					end
					rd_ptr_d = ctdq_pkg::next_ptr(rd_ptr_q);
					fill_d   = fill_q - ctdq_pkg::CNT_W'(1);
					sent_d   = sent_q + ctdq_pkg::CTR_W'(1);
					mb_d     = mb_q - ctdq_pkg::MB_W'(1);
					bud_d    = bud_q - ctdq_pkg::BUD_W'(1);
					hold_v_d = 1'b1;
					hold_d   = '0;
					hold_d.emit_valid   = 1'b1;
					hold_d.emit_id      = head_id;
					hold_d.emit_len     = head_len;
					hold_d.emit_payload = head_pay;
					hold_d.queue_depth  = ctdq_pkg::depth_out(fill_d);
					hold_d.sent_total   = sent_d;
					hold_d.drop_total   = drop_q;
				end
			end
			ctdq_pkg::ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					hold_v_d = 1'b0;
					if (hold_v_q) begin
						out_d = hold_q;
					end else begin
						out_d             = '0;
						out_d.queue_depth = ctdq_pkg::depth_out(fill_q);
						out_d.sent_total  = sent_q;
						out_d.drop_total  = drop_q;
					end
					out_d.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctdq_pkg::ST_IDLE;
			link_en_q   <= 1'b0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			fill_q      <= '0;
			sent_q      <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
			hold_v_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			fill_q   <= fill_d;
			sent_q   <= sent_d;
			drop_q   <= drop_d;
			hold_v_q <= hold_v_d;
			if (cfg_we) begin
				link_en_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			id_q   <= frame_id;
			len_q  <= frame_len;
			pay_q  <= frame_payload;
			boff_q <= bus_is_off;
			mb_q   <= free_mailboxes;
			bud_q  <= ctdq_pkg::BUD_W'(ctdq_pkg::DRAIN_BUDGET);
		end else begin
			mb_q  <= mb_d;
			bud_q <= bud_d;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		hold_q <= hold_d;
	end

	assign out_valid      = out_valid_q;
	assign emit_valid     = out_q.emit_valid;
	assign emit_id        = out_q.emit_id;
	assign emit_len       = out_q.emit_len;
	assign emit_payload   = out_q.emit_payload;
	assign accepted       = out_q.accepted;
	assign dropped_oldest = out_q.dropped_oldest;
	assign queue_depth    = out_q.queue_depth;
	assign sent_total     = out_q.sent_total;
	assign drop_total     = out_q.drop_total;
	assign last           = out_q.last;

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ctdq_pkg::CNT_W'(ctdq_pkg::QUEUE_DEPTH))
		else $error("queue fill above depth");

	ap_emit_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.emit_valid |-> out_q.emit_len <= ctdq_pkg::MAX_LEN)
		else $error("frame with invalid length handed to mailbox");

	ap_drop_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.dropped_oldest |-> out_q.accepted && !out_q.emit_valid)
		else $error("drop flag without queued submit");

	ap_sent_step: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q != $past(sent_q) |-> sent_q == $past(sent_q) + ctdq_pkg::CTR_W'(1))
		else $error("sent counter jumped");

	ap_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (state_q == ctdq_pkg::ST_RD) || (state_q == ctdq_pkg::ST_CHK) ||
		             (state_q == ctdq_pkg::ST_FLUSH))
		else $error("held drain word outside drain");

endmodule
